/* hw/rtl/idc_pkg.sv */
// Shared types, constants and calendar helpers for the ISO date age checker.
// No dependencies; imported by every module of the block.
package idc_pkg;

    // Per-date classification reported on the result channel
    typedef enum logic [1:0] {
        ST_VALID = 2'd0,
        ST_EMPTY = 2'd1,
        ST_BAD   = 2'd2
    } t_status;

    // Pipeline load enables, one per register stage
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } t_pipe_ctl;

    localparam int DATE_LEN          = 10;
    localparam int DASH_POS_A        = 4;
    localparam int DASH_POS_B        = 7;
    localparam int EPOCH_YEAR        = 1970;
    localparam int DAYS_PER_YEAR     = 365;
    // Days from 0000-03-01 to 1970-01-01 in the proleptic calendar;
    // 400-year era of 146097 days is folded into 365*y + y/4 - y/100 + y/400.
    localparam int DAYS_EPOCH_OFFSET = 719468;
    localparam logic [7:0] CHR_DASH  = 8'h2D;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHR_ZERO) && (c <= CHR_NINE);
    endfunction

    // Two decimal digits to a binary value, 0..99 for real digits
    function automatic logic [6:0] two_digit(input logic [3:0] hi, input logic [3:0] lo);
        return 7'({3'b000, hi} * 7'd10) + 7'({3'b000, lo});
    endfunction

    // Leap rule on the century part and the last two digits of the year
    function automatic logic leap_year(input logic [6:0] cent, input logic [6:0] yy);
        if (yy != 7'd0) begin
            return (yy[1:0] == 2'b00);
        end
        return (cent[1:0] == 2'b00);
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        unique case (mon)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // Day of a March-based year at which the month starts: (153*mp + 2) / 5
    function automatic logic [8:0] month_start(input logic [3:0] mon);
        logic [8:0] doy;
        unique case (mon)
            4'd3:    doy = 9'd0;
            4'd4:    doy = 9'd31;
            4'd5:    doy = 9'd61;
            4'd6:    doy = 9'd92;
            4'd7:    doy = 9'd122;
            4'd8:    doy = 9'd153;
            4'd9:    doy = 9'd184;
            4'd10:   doy = 9'd214;
            4'd11:   doy = 9'd245;
            4'd12:   doy = 9'd275;
            4'd1:    doy = 9'd306;
            4'd2:    doy = 9'd337;
            default: doy = 9'd0;
        endcase
        return doy;
    endfunction

endpackage

/* hw/rtl/idc_date_lane.sv */
// One date lane: format check in stage 1, day-number conversion in stage 2.
// Depends on idc_pkg; two instances run side by side in iso_date_age_checker.
module idc_date_lane (
    input  logic               i_clk,
    input  idc_pkg::t_pipe_ctl i_ctl,
    input  logic [63:0]        i_text_high,
    input  logic [15:0]        i_text_low,
    input  logic [3:0]         i_length,
    output idc_pkg::t_status   o_status,
    output logic [21:0]        o_day_number
);
    import idc_pkg::*;

    logic [7:0]  w_chr [DATE_LEN];
    logic        w_fmt_ok;
    logic [6:0]  w_cent;
    logic [6:0]  w_yy;
    logic [6:0]  w_mon;
    logic [6:0]  w_day;
    logic [13:0] w_year;
    logic        w_leap;
    logic        w_range_ok;
    t_status     n_status1;

    t_status     r_status1;
    logic [13:0] r_year;
    logic [6:0]  r_cent;
    logic [6:0]  r_yy;
    logic [3:0]  r_mon;
    logic [4:0]  r_day;

    logic        w_jan_feb;
    logic [13:0] w_year_m;
    logic [6:0]  w_cent_m;
    logic [22:0] w_days;
    logic [21:0] n_days;

    t_status     r_status2;
    logic [21:0] r_days;

    // Stage 1: unpack characters and check the text
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_chr[i] = i_text_high[63 - 8 * i -: 8];
        end
        w_chr[8] = i_text_low[15:8];
        w_chr[9] = i_text_low[7:0];
        w_fmt_ok = (i_length == 4'(DATE_LEN));
        for (int i = 0; i < DATE_LEN; i++) begin
            if (i == DASH_POS_A || i == DASH_POS_B) begin
                if (w_chr[i] != CHR_DASH) w_fmt_ok = 1'b0;
            end else begin
                if (!is_digit(w_chr[i])) w_fmt_ok = 1'b0;
            end
        end
    end

    assign w_cent = two_digit(w_chr[0][3:0], w_chr[1][3:0]);
    assign w_yy   = two_digit(w_chr[2][3:0], w_chr[3][3:0]);
    assign w_mon  = two_digit(w_chr[5][3:0], w_chr[6][3:0]);
    assign w_day  = two_digit(w_chr[8][3:0], w_chr[9][3:0]);
    assign w_year = 14'({7'd0, w_cent} * 14'd100) + {7'd0, w_yy};
    assign w_leap = leap_year(w_cent, w_yy);

    always_comb begin
        w_range_ok = (w_year >= 14'(EPOCH_YEAR))
                   && (w_mon >= 7'd1) && (w_mon <= 7'd12)
                   && (w_day != 7'd0)
                   && (w_day <= {2'b00, month_days(w_mon[3:0], w_leap)});
        priority if (i_length == 4'd0) begin
            n_status1 = ST_EMPTY;
        end else if (w_fmt_ok && w_range_ok) begin
            n_status1 = ST_VALID;
        end else begin
            n_status1 = ST_BAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld1) begin
            r_status1 <= n_status1;
            r_year    <= w_year;
            r_cent    <= w_cent;
            r_yy      <= w_yy;
            r_mon     <= w_mon[3:0];
            r_day     <= w_day[4:0];
        end
    end

    // Stage 2: days since epoch, year counted from March
    assign w_jan_feb = (r_mon <= 4'd2);
    assign w_year_m  = r_year - 14'(w_jan_feb);
    assign w_cent_m  = r_cent - 7'(w_jan_feb && (r_yy == 7'd0));
    assign w_days = 23'({9'd0, w_year_m} * 23'(DAYS_PER_YEAR))
                  + 23'(w_year_m[13:2])
                  - 23'(w_cent_m)
                  + 23'(w_cent_m[6:2])
                  + 23'(month_start(r_mon))
                  + 23'(r_day)
                  - 23'd1
                  - 23'(DAYS_EPOCH_OFFSET);
    assign n_days = (r_status1 == ST_VALID) ? w_days[21:0] : 22'd0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            r_status2 <= r_status1;
            r_days    <= n_days;
        end
    end

    assign o_status     = r_status2;
    assign o_day_number = r_days;

endmodule

/* hw/rtl/idc_merge.sv */
// Merge stage: age difference and stale flag from the two lane results.
// Depends on idc_pkg; fed by the two idc_date_lane instances.
module idc_merge (
    input  logic               i_clk,
    input  idc_pkg::t_pipe_ctl i_ctl,
    input  idc_pkg::t_status   i_src_status,
    input  idc_pkg::t_status   i_cur_status,
    input  logic [21:0]        i_src_days,
    input  logic [21:0]        i_cur_days,
    input  logic [21:0]        i_max_age,
    output idc_pkg::t_status   o_src_status,
    output idc_pkg::t_status   o_cur_status,
    output logic [21:0]        o_src_days,
    output logic [21:0]        o_cur_days,
    output logic [22:0]        o_age,
    output logic               o_stale
);
    import idc_pkg::*;

    logic        w_both;
    logic [22:0] w_diff;
    logic [22:0] n_age;
    logic        n_stale;

    t_status     r_src_status;
    t_status     r_cur_status;
    logic [21:0] r_src_days;
    logic [21:0] r_cur_days;
    logic [22:0] r_age;
    logic        r_stale;

    assign w_both  = (i_src_status == ST_VALID) && (i_cur_status == ST_VALID);
    assign w_diff  = {1'b0, i_cur_days} - {1'b0, i_src_days};
    assign n_age   = w_both ? w_diff : 23'd0;
    // negative age is never stale
    assign n_stale = w_both && !w_diff[22] && (w_diff[21:0] > i_max_age);

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld3) begin
            r_src_status <= i_src_status;
            r_cur_status <= i_cur_status;
            r_src_days   <= i_src_days;
            r_cur_days   <= i_cur_days;
            r_age        <= n_age;
            r_stale      <= n_stale;
        end
    end

    assign o_src_status = r_src_status;
    assign o_cur_status = r_cur_status;
    assign o_src_days   = r_src_days;
    assign o_cur_days   = r_cur_days;
    assign o_age        = r_age;
    assign o_stale      = r_stale;

endmodule

/* hw/rtl/iso_date_age_checker.sv */
// Top level of the ISO date age checker: handshake, config register, pipeline.
// Depends on idc_pkg, idc_date_lane and idc_merge.
//
// Usage:
//   Input channel (i_valid / o_stall) carries two YYYY-MM-DD strings with
//   their lengths; a transfer happens when i_valid is high and o_stall low.
//   Output channel (o_valid / i_stall) gives one result per input transfer:
//   status and day number of each date, signed age and the stale flag.
//   Config channel (i_cfg_valid / o_cfg_ready) writes max_age_days; ready is
//   always high. Write it only while no item is in flight.
//   The result passes three registers from input transfer to o_valid: text check, day-number
//   conversion (one lane per date), then the merge register for age and stale.
//   Throughput is one item per cycle while o_stall is low.
//   When i_stall is high the result holds; the three stages keep filling and
//   o_stall rises only when all three hold an item and the output is stalled.
//   Reset (synchronous, active low) empties the pipeline and clears the
//   maximum age to zero.
module iso_date_age_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_source_text_high,
    input  logic [15:0] i_source_text_low,
    input  logic [3:0]  i_source_length,
    input  logic [63:0] i_current_text_high,
    input  logic [15:0] i_current_text_low,
    input  logic [3:0]  i_current_length,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_source_status,
    output logic [1:0]  o_current_status,
    output logic [21:0] o_source_day_number,
    output logic [21:0] o_current_day_number,
    output logic [22:0] o_age_days,
    output logic        o_stale,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [21:0] i_cfg_data
);
    import idc_pkg::*;

    t_pipe_ctl   w_ctl;
    logic        r_vld1;
    logic        r_vld2;
    logic        r_vld3;
    logic [21:0] r_max_age;

    t_status     w_src_status;
    t_status     w_cur_status;
    logic [21:0] w_src_days;
    logic [21:0] w_cur_days;
    t_status     w_out_src_status;
    t_status     w_out_cur_status;

    // A stage loads when it is empty or its content moves on
    assign w_ctl.ld3 = !r_vld3 || !i_stall;
    assign w_ctl.ld2 = !r_vld2 || w_ctl.ld3;
    assign w_ctl.ld1 = !r_vld1 || w_ctl.ld2;

    assign o_stall     = !w_ctl.ld1;
    assign o_valid     = r_vld3;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1    <= 1'b0;
            r_vld2    <= 1'b0;
            r_vld3    <= 1'b0;
            r_max_age <= 22'd0;
        end else begin
            if (w_ctl.ld1) r_vld1 <= i_valid;
            if (w_ctl.ld2) r_vld2 <= r_vld1;
            if (w_ctl.ld3) r_vld3 <= r_vld2;
            if (i_cfg_valid && o_cfg_ready) r_max_age <= i_cfg_data;
        end
    end

    idc_date_lane u_src_lane (
        .i_clk        (i_clk),
        .i_ctl        (w_ctl),
        .i_text_high  (i_source_text_high),
        .i_text_low   (i_source_text_low),
        .i_length     (i_source_length),
        .o_status     (w_src_status),
        .o_day_number (w_src_days)
    );

    idc_date_lane u_cur_lane (
        .i_clk        (i_clk),
        .i_ctl        (w_ctl),
        .i_text_high  (i_current_text_high),
        .i_text_low   (i_current_text_low),
        .i_length     (i_current_length),
        .o_status     (w_cur_status),
        .o_day_number (w_cur_days)
    );

    idc_merge u_merge (
        .i_clk        (i_clk),
        .i_ctl        (w_ctl),
        .i_src_status (w_src_status),
        .i_cur_status (w_cur_status),
        .i_src_days   (w_src_days),
        .i_cur_days   (w_cur_days),
        .i_max_age    (r_max_age),
        .o_src_status (w_out_src_status),
        .o_cur_status (w_out_cur_status),
        .o_src_days   (o_source_day_number),
        .o_cur_days   (o_current_day_number),
        .o_age        (o_age_days),
        .o_stale      (o_stale)
    );

    assign o_source_status  = w_out_src_status;
    assign o_current_status = w_out_cur_status;

    // Stall upstream only with a full pipeline behind a stalled output
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_vld1 && r_vld2 && r_vld3 && i_stall))
        else $error("input stalled while pipeline has room");

    a_stale_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stale) |->
            (o_source_status == ST_VALID && o_current_status == ST_VALID))
        else $error("stale set without two valid dates");

    a_age_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_age_days != 23'd0) |->
            (o_source_status == ST_VALID && o_current_status == ST_VALID))
        else $error("nonzero age without two valid dates");

    a_days_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_source_status != ST_VALID) |-> (o_source_day_number == 22'd0))
        else $error("day number on an invalid source date");

endmodule

/* tb/iso_date_age_checker_test.sv */
// Self-checking testbench for iso_date_age_checker: directed and random date pairs,
// random idling on both channels, max_age_days swept across phases.
// Depends on idc_pkg and the iso_date_age_checker RTL.
module iso_date_age_checker_test;
    import idc_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASE_ITEMS   = 204;
    localparam int HOLD_AFTER    = 300;
    localparam int HOLD_CYCLES   = 400;

    typedef struct {
        logic [63:0] hi;
        logic [15:0] lo;
        logic [3:0]  len;
    } t_date_text;

    typedef struct {
        t_date_text src;
        t_date_text cur;
    } t_date_pair;

    typedef struct {
        t_status     src_status;
        t_status     cur_status;
        logic [21:0] src_day;
        logic [21:0] cur_day;
        logic [22:0] age;
        logic        stale;
    } t_age_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [63:0] i_source_text_high = '0;
    logic [15:0] i_source_text_low = '0;
    logic [3:0]  i_source_length = '0;
    logic [63:0] i_current_text_high = '0;
    logic [15:0] i_current_text_low = '0;
    logic [3:0]  i_current_length = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_source_status;
    logic [1:0]  o_current_status;
    logic [21:0] o_source_day_number;
    logic [21:0] o_current_day_number;
    logic [22:0] o_age_days;
    logic        o_stale;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [21:0] i_cfg_data = '0;

    t_date_pair  pending_pairs[$];
    t_age_result age_results_due[$];
    logic [21:0] max_age_model = '0;
    int          cfg_writes = 0;
    int          results_seen = 0;
    int          fail_count = 0;
    int          cycle_count = 0;
    bit          in_accepted = 1'b0;
    int          send_gap = 0;
    int          tx_calm = 0;
    int          rx_calm = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    iso_date_age_checker u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_source_text_high   (i_source_text_high),
        .i_source_text_low    (i_source_text_low),
        .i_source_length      (i_source_length),
        .i_current_text_high  (i_current_text_high),
        .i_current_text_low   (i_current_text_low),
        .i_current_length     (i_current_length),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_source_status      (o_source_status),
        .o_current_status     (o_current_status),
        .o_source_day_number  (o_source_day_number),
        .o_current_day_number (o_current_day_number),
        .o_age_days           (o_age_days),
        .o_stale              (o_stale),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_data           (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- calendar
    function automatic int unsigned gregorian_month_len(input int unsigned yr,
                                                        input int unsigned mo);
        int unsigned lens [12];
        bit          leap;
        lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
        if (mo == 2 && leap) return 29;
        return lens[(mo - 1) % 12];
    endfunction

    function automatic t_status classify_date(input t_date_text t,
                                              output int unsigned day_num);
        logic [7:0]  ch [10];
        int unsigned yr, mo, dy, era, yoe, mp, doy, doe;
        int          k;
        day_num = 0;
        if (t.len == 4'd0) return ST_EMPTY;
        if (t.len != 4'(DATE_LEN)) return ST_BAD;
        for (k = 0; k < 8; k++) ch[k] = t.hi[63 - 8*k -: 8];
        ch[8] = t.lo[15:8];
        ch[9] = t.lo[7:0];
        for (k = 0; k < DATE_LEN; k++) begin
            if (k == DASH_POS_A || k == DASH_POS_B) begin
                if (ch[k] != CHR_DASH) return ST_BAD;
            end else if (ch[k] < CHR_ZERO || ch[k] > CHR_NINE) begin
                return ST_BAD;
            end
        end
        yr = int'(ch[0] - CHR_ZERO) * 1000 + int'(ch[1] - CHR_ZERO) * 100
           + int'(ch[2] - CHR_ZERO) * 10 + int'(ch[3] - CHR_ZERO);
        mo = int'(ch[5] - CHR_ZERO) * 10 + int'(ch[6] - CHR_ZERO);
        dy = int'(ch[8] - CHR_ZERO) * 10 + int'(ch[9] - CHR_ZERO);
        if (yr < EPOCH_YEAR || mo == 0 || mo > 12 || dy == 0 ||
            dy > gregorian_month_len(yr, mo)) return ST_BAD;
        // March-based year: Jan and Feb belong to the previous year
        if (mo <= 2) yr--;
        era = yr / 400;
        yoe = yr - era * 400;
        mp  = (mo > 2) ? mo - 3 : mo + 9;
        doy = (153 * mp + 2) / 5 + dy - 1;
        doe = yoe * DAYS_PER_YEAR + yoe / 4 - yoe / 100 + doy;
        day_num = era * 146097 + doe - DAYS_EPOCH_OFFSET;
        return ST_VALID;
    endfunction

    function automatic t_age_result compute_age_result(input t_date_text src,
                                                       input t_date_text cur,
                                                       input logic [21:0] max_age);
        t_age_result r;
        int unsigned sd, cd;
        int          age, max_i;
        r.src_status = classify_date(src, sd);
        r.cur_status = classify_date(cur, cd);
        r.src_day = 22'(sd);
        r.cur_day = 22'(cd);
        age = 0;
        max_i = max_age;
        r.stale = 1'b0;
        if (r.src_status == ST_VALID && r.cur_status == ST_VALID) begin
            age = int'(cd) - int'(sd);
            r.stale = (age > max_i);
        end
        r.age = 23'(age);
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers
    function automatic logic [7:0] ascii_digit(input int v);
        return CHR_ZERO + 8'(v);
    endfunction

    function automatic t_date_text make_date(input int yr, input int mo, input int dy);
        t_date_text t;
        t.hi = {ascii_digit(yr / 1000), ascii_digit(yr / 100 % 10),
                ascii_digit(yr / 10 % 10), ascii_digit(yr % 10), CHR_DASH,
                ascii_digit(mo / 10), ascii_digit(mo % 10), CHR_DASH};
        t.lo = {ascii_digit(dy / 10), ascii_digit(dy % 10)};
        t.len = 4'(DATE_LEN);
        return t;
    endfunction

    function automatic t_date_text with_char(input t_date_text t, input int pos,
                                             input logic [7:0] ch);
        if (pos < 8) t.hi[63 - 8*pos -: 8] = ch;
        else if (pos == 8) t.lo[15:8] = ch;
        else t.lo[7:0] = ch;
        return t;
    endfunction

    function automatic t_date_text with_len(input t_date_text t, input logic [3:0] len);
        t.len = len;
        return t;
    endfunction

    // Mostly short gaps, some longer ones, now and then a calm run with none
    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm = $urandom_range(20, 120);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] near_miss_char();
        case ($urandom_range(0, 5))
            0: return 8'h2F;  // just below '0'
            1: return 8'h3A;  // just above '9'
            2: return 8'h2B;  // plus sign
            3: return CHR_DASH;
            4: return 8'h20;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_date_text random_date(input int yr_lo, input int yr_hi);
        t_date_text t;
        int kind, yr, mo, dy, mlen, len;
        kind = $urandom_range(0, 99);
        yr = $urandom_range(yr_lo, yr_hi);
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 5))
                0: yr = 1972;
                1: yr = 2000;
                2: yr = 2100;
                3: yr = 2400;
                4: yr = EPOCH_YEAR;
                default: yr = 9999;
            endcase
        end
        mo = $urandom_range(1, 12);
        mlen = gregorian_month_len(yr, mo);
        dy = ($urandom_range(0, 7) == 0) ? mlen : $urandom_range(1, mlen);
        if (kind >= 64 && kind < 70) yr = $urandom_range(0, EPOCH_YEAR - 1);
        else if (kind >= 70 && kind < 75) mo = $urandom_range(0, 1) ? 0 : $urandom_range(13, 99);
        else if (kind >= 75 && kind < 81) begin
            case ($urandom_range(0, 2))
                0: dy = 0;
                1: dy = mlen + 1;
                default: dy = $urandom_range(mlen + 1, 99);
            endcase
        end
        t = make_date(yr, mo, dy);
        if (kind >= 81 && kind < 88) begin
            t = with_char(t, $urandom_range(0, 9),
                          $urandom_range(0, 1) ? near_miss_char() : 8'($urandom));
        end else if (kind >= 88 && kind < 94) begin
            len = $urandom_range(0, 15);
            if (len == DATE_LEN) len = 0;
            t.len = 4'(len);
            if ($urandom_range(0, 1)) begin
                t.hi = {$urandom, $urandom};
                t.lo = 16'($urandom);
            end
        end else if (kind >= 94) begin
            t.hi = {$urandom, $urandom};
            t.lo = 16'($urandom);
        end
        return t;
    endfunction

    task automatic push_pair(input t_date_text src, input t_date_text cur);
        t_date_pair p;
        p.src = src;
        p.cur = cur;
        pending_pairs.insert(pending_pairs.size(), p);
    endtask

    task automatic push_random_pair();
        int base;
        if ($urandom_range(0, 1)) begin
            // nearby dates so the age lands around the stale threshold
            base = $urandom_range(EPOCH_YEAR, 9997);
            push_pair(random_date(base, base + 1), random_date(base, base + 2));
        end else begin
            push_pair(random_date(EPOCH_YEAR, 2100), random_date(EPOCH_YEAR, 9999));
        end
    endtask

    task automatic drain_pipeline();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_pairs.size() != 0 || i_valid || age_results_due.size() != 0);
    endtask

    task automatic write_max_age(input logic [21:0] value);
        int seen;
        seen = cfg_writes;
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        while (cfg_writes == seen) @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // ---------------------------------------------------------------- sender
    always @(negedge i_clk) begin
        t_date_pair nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_accepted) begin
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
                nxt = pending_pairs.pop_front();
                i_source_text_high  <= nxt.src.hi;
                i_source_text_low   <= nxt.src.lo;
                i_source_length     <= nxt.src.len;
                i_current_text_high <= nxt.cur.hi;
                i_current_text_low  <= nxt.cur.lo;
                i_current_length    <= nxt.cur.len;
                i_valid <= 1'b1;
                send_gap = idle_len(tx_calm);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- receiver stall
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            // long hold-off while the sender keeps offering: pipeline fills up
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            stall_left = idle_len(rx_calm);
        end
    end

    // ---------------------------------------------------------------- predict and check
    always @(posedge i_clk) begin
        t_date_text  src, cur;
        t_age_result want;
        t_age_result due;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                max_age_model = i_cfg_data;
                cfg_writes++;
            end
            in_accepted = i_rst_n && i_valid && !o_stall;
            if (in_accepted) begin
                src.hi  = i_source_text_high;
                src.lo  = i_source_text_low;
                src.len = i_source_length;
                cur.hi  = i_current_text_high;
                cur.lo  = i_current_text_low;
                cur.len = i_current_length;
                due = compute_age_result(src, cur, max_age_model);
                age_results_due.insert(age_results_due.size(), due);
            end
            if (i_rst_n && o_valid && !i_stall) begin
                results_seen++;
                if (age_results_due.size() == 0) begin
                    $display("%0t: result transfer with none expected", $time);
                    fail_count++;
                end else begin
                    want = age_results_due.pop_front();
                    check_field("source_status", want.src_status, o_source_status);
                    check_field("current_status", want.cur_status, o_current_status);
                    check_field("source_day_number", want.src_day, o_source_day_number);
                    check_field("current_day_number", want.cur_day, o_current_day_number);
                    check_field("age_days", $signed(want.age), $signed(o_age_days));
                    check_field("stale", want.stale, o_stale);
                end
            end
        end
    end

    // ---------------------------------------------------------------- sequence
    initial begin
        logic [21:0] limits [7];
        int          ph, n;
        limits = '{22'h3FFFFF, 22'd0, 22'd365, 22'd30, 22'($urandom), 22'd1, 22'd2932896};

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed pairs, max age still at its reset value
        push_pair(make_date(1970, 1, 1), make_date(1970, 1, 1));
        push_pair(make_date(1970, 1, 1), make_date(9999, 12, 31));
        push_pair(make_date(9999, 12, 31), make_date(1970, 1, 1));
        push_pair(make_date(1970, 1, 1), make_date(1970, 1, 2));
        push_pair(make_date(2000, 2, 29), make_date(2024, 2, 29));
        push_pair(make_date(2100, 2, 29), make_date(2023, 2, 29));
        push_pair(make_date(1969, 12, 31), make_date(0, 1, 1));
        push_pair(make_date(2020, 0, 10), make_date(2020, 13, 1));
        push_pair(make_date(2020, 1, 0), make_date(2020, 1, 32));
        push_pair(make_date(2021, 4, 31), make_date(2021, 6, 30));
        push_pair(with_len(make_date(2001, 5, 5), 4'd0), with_len('{'1, '1, 4'd0}, 4'd0));
        push_pair(with_len(make_date(2001, 5, 5), 4'd9), with_len(make_date(2001, 5, 5), 4'd11));
        push_pair(with_len(make_date(2001, 5, 5), 4'd15), with_len(make_date(2001, 5, 5), 4'd1));
        push_pair(with_char(make_date(2001, 5, 5), 0, 8'h2B),
                  with_char(make_date(2001, 5, 5), 5, CHR_DASH));
        push_pair(with_char(make_date(2001, 5, 5), DASH_POS_A, 8'h2F),
                  with_char(make_date(2001, 5, 5), 9, 8'h3A));
        push_pair(with_char(make_date(2001, 5, 5), DASH_POS_B, 8'h3A),
                  with_char(make_date(2001, 5, 5), 3, 8'h2F));
        push_pair(make_date(2400, 2, 29), make_date(1970, 3, 1));
        push_pair(make_date(1972, 2, 29), make_date(1970, 2, 28));
        push_pair('{'1, '1, 4'd10}, '{'0, '0, 4'd10});
        push_pair(with_len(make_date(1999, 9, 9), 4'd0), make_date(1999, 12, 31));
        push_pair(make_date(2023, 12, 31), make_date(2024, 1, 1));
        drain_pipeline();

        for (ph = 0; ph < 7; ph++) begin
            write_max_age(limits[ph]);
            for (n = 0; n < PHASE_ITEMS; n++) push_random_pair();
            drain_pipeline();
        end

        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && age_results_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
